>>> hw/rtl/dwsp_pkg.sv
package dwsp_pkg;

  // field widths
  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 7;
  localparam int DRIVE_W    = 16;
  localparam int DRIVE_FRAC = 8;
  localparam int LIMIT_MAX  = 100;

  localparam int WINDOW_DEF = 5;

  // datapath widths derived from the field widths
  localparam int ERR_W = SAMPLE_W + 1;
  localparam int DP_W  = ERR_W + 1;
  localparam int DD_W  = ERR_W + 2;
  localparam int PP_W  = GAIN_W + 1 + DP_W;
  localparam int PI_W  = GAIN_W + 1 + ERR_W;
  localparam int PD_W  = GAIN_W + 1 + DD_W;
  localparam int TOT_W = PD_W + 2;
  localparam int INC_W = TOT_W - DRIVE_FRAC;
  localparam int ACC_W = INC_W + 1;

  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = DRIVE_W'(LIMIT_MAX << DRIVE_FRAC);

  // pipeline depth from accept to result register
  localparam int NSTAGE = 7;

  // configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_SAT_PCT
  } reg_idx_t;

  localparam logic [GAIN_W-1:0]  GAIN_P_RST  = GAIN_W'(676);
  localparam logic [GAIN_W-1:0]  GAIN_I_RST  = GAIN_W'(184);
  localparam logic [GAIN_W-1:0]  GAIN_D_RST  = GAIN_W'(0);
  localparam logic [LIMIT_W-1:0] SAT_PCT_RST = LIMIT_W'(100);

  // per-stage load strobes shared by both lanes
  typedef struct packed {
    logic [NSTAGE-1:0] load;
  } lane_ctl_t;

endpackage

>>> hw/rtl/dwsp_in_if.sv
interface dwsp_in_if;
  import dwsp_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_left;
  logic signed [SAMPLE_W-1:0] sample_right;
  logic signed [SAMPLE_W-1:0] target_left;
  logic signed [SAMPLE_W-1:0] target_right;
  logic                       clear_outputs;

  modport source (
    output valid, sample_left, sample_right, target_left, target_right, clear_outputs,
    input  ready
  );

  modport sink (
    input  valid, sample_left, sample_right, target_left, target_right, clear_outputs,
    output ready
  );

endinterface

>>> hw/rtl/dwsp_out_if.sv
interface dwsp_out_if;
  import dwsp_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [DRIVE_W-1:0]  drive_left;
  logic signed [DRIVE_W-1:0]  drive_right;
  logic signed [SAMPLE_W-1:0] avg_left;
  logic signed [SAMPLE_W-1:0] avg_right;

  modport source (
    output valid, drive_left, drive_right, avg_left, avg_right,
    input  ready
  );

  modport sink (
    input  valid, drive_left, drive_right, avg_left, avg_right,
    output ready
  );

endinterface

>>> hw/rtl/dual_wheel_speed_pi_loop_top.sv
// channel  | role   | handshake     | beat payload
// ---------+--------+---------------+-------------------------------------------------
// tick     | sink   | valid/ready   | sample_left/right, target_left/right, clear_outputs
// result   | source | valid/ready   | drive_left/right, avg_left/right
// apb      | slave  | psel/penable  | gain_p, gain_i, gain_d, sat_pct (4 byte stride)
//
// one tick beat per cycle sustained while result is taken, result passes 7 stages after accept
// the drive accumulator add/saturate and error history each close within their own stage
// rst (sync, high) clears window, sums, error history, drive and all stage valids
// a stalled result holds the last stage and every full stage behind it; empty stages upstream keep filling
// tick.ready drops only when every stage holds a beat and result is not taken
module dual_wheel_speed_pi_loop_top #(
  parameter int WINDOW = dwsp_pkg::WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  dwsp_in_if.sink                       tick,
  dwsp_out_if.source                    result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dwsp_pkg::ADDR_W-1:0]   paddr,
  input  logic [dwsp_pkg::DATA_W-1:0]   pwdata,
  output logic [dwsp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import dwsp_pkg::*;

  // configuration registers
  logic [GAIN_W-1:0]  gain_p;
  logic [GAIN_W-1:0]  gain_i;
  logic [GAIN_W-1:0]  gain_d;
  logic [LIMIT_W-1:0] sat_pct;

  logic               cfg_wr;
  reg_idx_t           cfg_idx;
  logic [LIMIT_W-1:0] lim_pct;
  logic signed [DRIVE_W-1:0] limit;

  lane_ctl_t ctl;
  logic      in_ready;
  logic      out_valid;

  logic signed [DRIVE_W-1:0]  drive_l, drive_r;
  logic signed [SAMPLE_W-1:0] avg_l, avg_r;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  // byte offset bits are ignored, word index picks the register
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p  <= GAIN_P_RST;
      gain_i  <= GAIN_I_RST;
      gain_d  <= GAIN_D_RST;
      sat_pct <= SAT_PCT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_GAIN_P:  gain_p  <= pwdata[GAIN_W-1:0];
        REG_GAIN_I:  gain_i  <= pwdata[GAIN_W-1:0];
        REG_GAIN_D:  gain_d  <= pwdata[GAIN_W-1:0];
        REG_SAT_PCT: sat_pct <= pwdata[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_GAIN_P:  prdata = DATA_W'(gain_p);
      REG_GAIN_I:  prdata = DATA_W'(gain_i);
      REG_GAIN_D:  prdata = DATA_W'(gain_d);
      REG_SAT_PCT: prdata = DATA_W'(sat_pct);
      default:     prdata = '0;
    endcase
  end

  // limit above 100 percent is held at 100, then scaled to 1/256 percent
  assign lim_pct = (sat_pct > LIMIT_W'(LIMIT_MAX)) ? LIMIT_W'(LIMIT_MAX) : sat_pct;
  assign limit   = DRIVE_W'({lim_pct, {DRIVE_FRAC{1'b0}}});

  // shared stage control for both wheels
  dwsp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tick.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (result.ready),
    .ctl       (ctl)
  );

  // left wheel lane
  dwsp_lane #(.WINDOW(WINDOW)) u_lane_left (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .sample (tick.sample_left),
    .target (tick.target_left),
    .clear  (tick.clear_outputs),
    .gain_p (gain_p),
    .gain_i (gain_i),
    .gain_d (gain_d),
    .limit  (limit),
    .drive  (drive_l),
    .avg    (avg_l)
  );

  // right wheel lane
  dwsp_lane #(.WINDOW(WINDOW)) u_lane_right (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .sample (tick.sample_right),
    .target (tick.target_right),
    .clear  (tick.clear_outputs),
    .gain_p (gain_p),
    .gain_i (gain_i),
    .gain_d (gain_d),
    .limit  (limit),
    .drive  (drive_r),
    .avg    (avg_r)
  );

  // merge both lanes' final stage into one result beat
  assign tick.ready         = in_ready;
  assign result.valid       = out_valid;
  assign result.drive_left  = drive_l;
  assign result.drive_right = drive_r;
  assign result.avg_left    = avg_l;
  assign result.avg_right   = avg_r;

`ifndef SYNTHESIS
  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    !tick.ready |-> result.valid)
    else $error("tick stalled while result stage empty");

  a_left_bound: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.drive_left <= DRIVE_MAX) && (result.drive_left >= -DRIVE_MAX))
    else $error("left drive out of saturation range");

  a_right_bound: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.drive_right <= DRIVE_MAX) && (result.drive_right >= -DRIVE_MAX))
    else $error("right drive out of saturation range");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result.valid)
    else $error("result valid right after reset");
`endif

endmodule

>>> hw/rtl/dwsp_ctrl.sv
module dwsp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output dwsp_pkg::lane_ctl_t ctl
);
  import dwsp_pkg::*;

  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] en;

  // a stage may load when it is empty or its content moves on
  always_comb begin
    en[NSTAGE-1] = !vld[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
    ctl.load[0] = en[0] && in_valid;
    for (int k = 1; k < NSTAGE; k++) begin
      ctl.load[k] = en[k] && vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= (vld & ~en) | ctl.load;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NSTAGE-1];

endmodule

>>> hw/rtl/dwsp_lane.sv
module dwsp_lane #(
  parameter int WINDOW = dwsp_pkg::WINDOW_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  dwsp_pkg::lane_ctl_t                  ctl,
  input  logic signed [dwsp_pkg::SAMPLE_W-1:0] sample,
  input  logic signed [dwsp_pkg::SAMPLE_W-1:0] target,
  input  logic                                 clear,
  input  logic        [dwsp_pkg::GAIN_W-1:0]   gain_p,
  input  logic        [dwsp_pkg::GAIN_W-1:0]   gain_i,
  input  logic        [dwsp_pkg::GAIN_W-1:0]   gain_d,
  input  logic signed [dwsp_pkg::DRIVE_W-1:0]  limit,
  output logic signed [dwsp_pkg::DRIVE_W-1:0]  drive,
  output logic signed [dwsp_pkg::SAMPLE_W-1:0] avg
);
  import dwsp_pkg::*;

  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);
  // floor(2^SUM_W / WINDOW): quotient estimate is low by at most one
  localparam logic [SUM_W-1:0] RECIP = SUM_W'((64'd1 << SUM_W) / WINDOW);
  localparam logic [SUM_W-1:0] WIN_C = SUM_W'(WINDOW);

  localparam int ST_SUM   = 0;
  localparam int ST_QEST  = 1;
  localparam int ST_AVG   = 2;
  localparam int ST_ERR   = 3;
  localparam int ST_MUL   = 4;
  localparam int ST_INC   = 5;
  localparam int ST_DRIVE = 6;

  // window and loop state
  logic signed [SAMPLE_W-1:0] taps [WINDOW];
  logic signed [SUM_W-1:0]    sum;
  logic signed [ERR_W-1:0]    e1;
  logic signed [ERR_W-1:0]    e2;

  // stage payload
  logic signed [SAMPLE_W-1:0] target0, target1, target2;
  logic                       clear0, clear1, clear2, clear3, clear4, clear5;
  logic        [SUM_W-1:0]    q1, mag1;
  logic                       neg1;
  logic signed [SAMPLE_W-1:0] avg2, avg3, avg4, avg5, avg6;
  logic signed [ERR_W-1:0]    e0_3;
  logic signed [DP_W-1:0]     dp3;
  logic signed [DD_W-1:0]     dd3;
  logic signed [PP_W-1:0]     pp4;
  logic signed [PI_W-1:0]     pi4;
  logic signed [PD_W-1:0]     pd4;
  logic signed [INC_W-1:0]    inc5;

  // combinational per stage
  logic        [SUM_W-1:0]    mag_c;
  logic        [2*SUM_W-1:0]  prod_c;
  logic        [SUM_W-1:0]    qw_c, rem_c, q_c, avg_c;
  logic signed [ERR_W-1:0]    e0_c;
  logic signed [DP_W-1:0]     dp_c;
  logic signed [DD_W-1:0]     dd_c;
  logic signed [PP_W-1:0]     pp_c;
  logic signed [PI_W-1:0]     pi_c;
  logic signed [PD_W-1:0]     pd_c;
  logic signed [TOT_W-1:0]    tot_c;
  logic signed [DRIVE_W-1:0]  base_c;
  logic signed [ACC_W-1:0]    acc_c, lim_c;
  logic signed [DRIVE_W-1:0]  drive_c;

  always_comb begin
    // magnitude and reciprocal multiply
    mag_c  = sum[SUM_W-1] ? (~sum + 1'b1) : sum;
    prod_c = {{SUM_W{1'b0}}, mag_c} * {{SUM_W{1'b0}}, RECIP};
    // one correction step on the quotient, then restore the sign
    qw_c  = q1 * WIN_C;
    rem_c = mag1 - qw_c;
    q_c   = q1 + SUM_W'(rem_c >= WIN_C);
    avg_c = neg1 ? (~q_c + 1'b1) : q_c;
    // error terms
    e0_c = ERR_W'(target2) - ERR_W'(avg2);
    dp_c = DP_W'(e0_c) - DP_W'(e1);
    dd_c = DD_W'(e0_c) - (DD_W'(e1) <<< 1) + DD_W'(e2);
    // gain products
    pp_c = $signed({1'b0, gain_p}) * dp3;
    pi_c = $signed({1'b0, gain_i}) * e0_3;
    pd_c = $signed({1'b0, gain_d}) * dd3;
    tot_c = TOT_W'(pp4) + TOT_W'(pi4) + TOT_W'(pd4);
    // accumulate and saturate
    base_c = clear5 ? '0 : drive;
    acc_c  = ACC_W'(base_c) + ACC_W'(inc5);
    lim_c  = ACC_W'(limit);
    if (acc_c > lim_c) begin
      drive_c = limit;
    end else if (acc_c < -lim_c) begin
      drive_c = -limit;
    end else begin
      drive_c = acc_c[DRIVE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) begin
        taps[i] <= '0;
      end
      sum   <= '0;
      e1    <= '0;
      e2    <= '0;
      drive <= '0;
    end else begin
      if (ctl.load[ST_SUM]) begin
        taps[0] <= sample;
        for (int i = 1; i < WINDOW; i++) begin
          taps[i] <= taps[i-1];
        end
        sum <= sum + SUM_W'(sample) - SUM_W'(taps[WINDOW-1]);
      end
      if (ctl.load[ST_ERR]) begin
        e2 <= e1;
        e1 <= e0_c;
      end
      if (ctl.load[ST_DRIVE]) begin
        drive <= drive_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[ST_SUM]) begin
      target0 <= target;
      clear0  <= clear;
    end
    if (ctl.load[ST_QEST]) begin
      q1      <= prod_c[2*SUM_W-1:SUM_W];
      mag1    <= mag_c;
      neg1    <= sum[SUM_W-1];
      target1 <= target0;
      clear1  <= clear0;
    end
    if (ctl.load[ST_AVG]) begin
      avg2    <= avg_c[SAMPLE_W-1:0];
      target2 <= target1;
      clear2  <= clear1;
    end
    if (ctl.load[ST_ERR]) begin
      e0_3   <= e0_c;
      dp3    <= dp_c;
      dd3    <= dd_c;
      avg3   <= avg2;
      clear3 <= clear2;
    end
    if (ctl.load[ST_MUL]) begin
      pp4    <= pp_c;
      pi4    <= pi_c;
      pd4    <= pd_c;
      avg4   <= avg3;
      clear4 <= clear3;
    end
    if (ctl.load[ST_INC]) begin
      inc5   <= tot_c[TOT_W-1:DRIVE_FRAC];
      avg5   <= avg4;
      clear5 <= clear4;
    end
    if (ctl.load[ST_DRIVE]) begin
      avg6 <= avg5;
    end
  end

  assign avg = avg6;

endmodule
